// File: rtl/drl_pkg.sv
// Shared types, constants and helper functions of the line rasterizer.
package drl_pkg;

  localparam int unsigned ROW_BYTES_DEFAULT = 40;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [16:0] SLOPE_ONE = 17'd100000;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned DIVIDEND_W = 25;

  localparam logic [2:0] REG_GRAPHICS_BASE = 3'd0;

  typedef enum logic [1:0] {
    MODE_VERT    = 2'd0,
    MODE_HORZ    = 2'd1,
    MODE_SHALLOW = 2'd2,
    MODE_STEEP   = 2'd3
  } line_mode_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  typedef enum logic {
    BK_READY,
    BK_DIVIDE
  } back_state_t;

  typedef struct packed {
    logic       is_step;
    logic [7:0] x_start;
    logic [6:0] y_start;
    logic       dir_x_neg;
    logic       dir_y_neg;
    line_mode_t mode;
    logic [7:0] major_delta;
    logic [7:0] minor_delta;
  } cmd_t;

  // Exact quotient by six for any 8-bit value, by reciprocal multiplication.
  function automatic logic [5:0] div6(input logic [7:0] v);
    logic [15:0] prod;
    prod = 16'(v) * 16'd171;
    return prod[15:10];
  endfunction

  function automatic logic [5:0] pix_mask(input logic [7:0] v);
    logic [5:0] q;
    logic [8:0] q6;
    logic [2:0] r;
    q  = div6(v);
    q6 = 9'(q) * 9'd6;
    r  = 3'(9'(v) - q6);
    return 6'b100000 >> r;
  endfunction

endpackage

// File: rtl/drl_if.sv
// Valid/ready channel interfaces for command items and pixel items.
interface drl_cmd_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] x_start;
  logic [6:0] y_start;
  logic [7:0] x_end;
  logic [6:0] y_end;

  modport source(output valid, func, x_start, y_start, x_end, y_end, input ready);
  modport sink(input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

interface drl_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pix_x;
  logic [6:0]  pix_y;
  logic [15:0] byte_address;
  logic [5:0]  bit_mask;
  logic        last;

  modport source(output valid, pix_x, pix_y, byte_address, bit_mask, last, input ready);
  modport sink(input valid, pix_x, pix_y, byte_address, bit_mask, last, output ready);
endinterface

// File: rtl/drl_front.sv
// Front end: accepts command items and classifies the line before queueing.
module drl_front (
  drl_cmd_if.sink          cmd,
  output drl_pkg::cmd_t    q_cmd,
  input  logic             q_full,
  output logic             q_push
);

  logic [7:0] adx;
  logic [7:0] ady;
  logic       x_neg;
  logic       y_neg;

  assign x_neg = cmd.x_end < cmd.x_start;
  assign y_neg = cmd.y_end < cmd.y_start;
  assign adx   = x_neg ? 8'(cmd.x_start - cmd.x_end) : 8'(cmd.x_end - cmd.x_start);
  assign ady   = y_neg ? 8'({1'b0, cmd.y_start} - {1'b0, cmd.y_end})
                       : 8'({1'b0, cmd.y_end} - {1'b0, cmd.y_start});

  assign cmd.ready = !q_full;
  assign q_push    = cmd.valid && !q_full;

  always_comb begin
    q_cmd.is_step   = (cmd.func == drl_pkg::FUNC_STEP);
    q_cmd.x_start   = cmd.x_start;
    q_cmd.y_start   = cmd.y_start;
    q_cmd.dir_x_neg = x_neg;
    q_cmd.dir_y_neg = y_neg;
    priority if (adx == 8'd0) begin
      q_cmd.mode        = drl_pkg::MODE_VERT;
      q_cmd.major_delta = ady;
      q_cmd.minor_delta = 8'd0;
    end else if (ady == 8'd0) begin
      q_cmd.mode        = drl_pkg::MODE_HORZ;
      q_cmd.major_delta = adx;
      q_cmd.minor_delta = 8'd0;
    end else if (ady <= adx) begin
      q_cmd.mode        = drl_pkg::MODE_SHALLOW;
      q_cmd.major_delta = adx;
      q_cmd.minor_delta = ady;
    end else begin
      q_cmd.mode        = drl_pkg::MODE_STEEP;
      q_cmd.major_delta = ady;
      q_cmd.minor_delta = adx;
    end
  end

endmodule

// File: rtl/drl_queue.sv
// Short command queue between the front end and the back end.
module drl_queue #(
  parameter int unsigned DEPTH = drl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  drl_pkg::cmd_t         wr_data,
  input  logic                  wr_en,
  output logic                  full,
  output drl_pkg::cmd_t         rd_data,
  input  logic                  rd_en,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  drl_pkg::cmd_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// File: rtl/drl_back.sv
// Back end: slope divider, line walker and registered pixel output.
module drl_back #(
  parameter int unsigned ROW_BYTES = drl_pkg::ROW_BYTES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     graphics_base,
  input  drl_pkg::cmd_t   q_cmd,
  input  logic            q_empty,
  output logic            q_pop,
  drl_pix_if.source       pix
);

  localparam int unsigned CNT_W = $clog2(drl_pkg::DIV_STEPS);

  drl_pkg::back_state_t state;
  drl_pkg::back_state_t state_next;

  logic                 active;
  drl_pkg::line_mode_t  mode;
  logic                 dir_x_neg;
  logic                 dir_y_neg;
  logic [7:0]           cur_x;
  logic [6:0]           cur_y;
  logic [7:0]           major_count;
  logic [7:0]           major_limit;
  logic [16:0]          slope;
  logic [17:0]          accum;

  logic [7:0]           div_rem;
  logic [16:0]          div_bits;
  logic [7:0]           div_den;
  logic [CNT_W-1:0]     div_cnt;

  logic                 out_valid;
  logic                 out_free;
  logic                 load;
  logic                 emit;
  logic                 div_iter;
  logic                 div_done;
  logic                 diagonal;
  logic                 major_is_y;
  logic                 is_last;

  logic [drl_pkg::DIVIDEND_W-1:0] dividend;
  logic [8:0]           trial;
  logic                 trial_ge;
  logic [8:0]           trial_diff;
  logic [17:0]          accum_sum;
  logic                 minor_move;
  logic [15:0]          address;

  assign out_free   = !out_valid || pix.ready;
  assign diagonal   = (q_cmd.mode == drl_pkg::MODE_SHALLOW) || (q_cmd.mode == drl_pkg::MODE_STEEP);
  assign div_done   = (div_cnt == CNT_W'(drl_pkg::DIV_STEPS - 1));
  assign major_is_y = (mode == drl_pkg::MODE_VERT) || (mode == drl_pkg::MODE_STEEP);
  assign is_last    = (major_count == major_limit);

  always_comb begin
    state_next = state;
    unique case (state)
      drl_pkg::BK_READY: begin
        if (load && diagonal) begin
          state_next = drl_pkg::BK_DIVIDE;
        end
      end
      drl_pkg::BK_DIVIDE: begin
        if (div_done) begin
          state_next = drl_pkg::BK_READY;
        end
      end
      default: state_next = drl_pkg::BK_READY;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    div_iter = 1'b0;
    unique case (state)
      drl_pkg::BK_READY: begin
        if (!q_empty && (!q_cmd.is_step || out_free)) begin
          q_pop = 1'b1;
        end
      end
      drl_pkg::BK_DIVIDE: begin
        div_iter = 1'b1;
      end
      default: begin
        q_pop    = 1'b0;
        div_iter = 1'b0;
      end
    endcase
  end

  assign load = q_pop && !q_cmd.is_step;
  assign emit = q_pop && q_cmd.is_step && active;

  assign dividend   = drl_pkg::DIVIDEND_W'(q_cmd.minor_delta)
                    * drl_pkg::DIVIDEND_W'(drl_pkg::SLOPE_ONE);
  assign trial      = {div_rem, div_bits[16]};
  assign trial_ge   = trial >= {1'b0, div_den};
  assign trial_diff = trial - {1'b0, div_den};

  assign accum_sum  = accum + 18'(slope);
  assign minor_move = (mode == drl_pkg::MODE_SHALLOW || mode == drl_pkg::MODE_STEEP)
                    && (accum_sum >= 18'(drl_pkg::SLOPE_ONE));

  assign address = 16'(graphics_base + 16'(drl_pkg::div6(cur_x))
                 + 16'(cur_y) * 16'(ROW_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= drl_pkg::BK_READY;
      active      <= 1'b0;
      out_valid   <= 1'b0;
      mode        <= drl_pkg::MODE_VERT;
      major_count <= '0;
      major_limit <= '0;
      slope       <= '0;
      accum       <= '0;
      div_cnt     <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end

      if (load) begin
        active      <= 1'b1;
        mode        <= q_cmd.mode;
        major_limit <= q_cmd.major_delta;
        major_count <= '0;
        slope       <= '0;
        accum       <= '0;
        div_cnt     <= '0;
      end else if (div_iter) begin
        slope   <= {slope[15:0], trial_ge};
        div_cnt <= CNT_W'(div_cnt + 1'b1);
      end else if (emit) begin
        if (minor_move) begin
          accum <= 18'(accum_sum - 18'(drl_pkg::SLOPE_ONE));
        end else if (mode == drl_pkg::MODE_SHALLOW || mode == drl_pkg::MODE_STEEP) begin
          accum <= accum_sum;
        end
        if (is_last) begin
          active <= 1'b0;
        end else begin
          major_count <= 8'(major_count + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x     <= q_cmd.x_start;
      cur_y     <= q_cmd.y_start;
      dir_x_neg <= q_cmd.dir_x_neg;
      dir_y_neg <= q_cmd.dir_y_neg;
      div_den   <= q_cmd.major_delta;
      div_rem   <= dividend[drl_pkg::DIVIDEND_W-1:drl_pkg::DIV_STEPS];
      div_bits  <= dividend[drl_pkg::DIV_STEPS-1:0];
    end else if (div_iter) begin
      div_rem  <= trial_ge ? trial_diff[7:0] : trial[7:0];
      div_bits <= {div_bits[15:0], 1'b0};
    end else if (emit) begin
      if (major_is_y || minor_move) begin
        cur_y <= dir_y_neg ? 7'(cur_y - 1'b1) : 7'(cur_y + 1'b1);
      end
      if (!major_is_y || minor_move) begin
        cur_x <= dir_x_neg ? 8'(cur_x - 1'b1) : 8'(cur_x + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix.pix_x        <= cur_x;
      pix.pix_y        <= cur_y;
      pix.byte_address <= address;
      pix.bit_mask     <= drl_pkg::pix_mask(cur_x);
      pix.last         <= is_last;
    end
  end

  assign pix.valid = out_valid;

endmodule

// File: rtl/dda_line_pixel_rasterizer_unit.sv
// Top level of the line rasterizer: configuration port, front end, queue and back end.
// A step item yields its pixel in the cycle after it leaves the queue; steps run one per
// cycle while the pixel output is not stalled. A start item for a diagonal line runs the
// one-bit-per-cycle restoring divider that forms the 17-bit slope; the queue waits meanwhile.
// Items enter the queue at one per cycle while it has room, so an item may also wait in the queue.
// Synchronous reset clears the queue, the walker and the output valid; no clearing pass.
module dda_line_pixel_rasterizer_unit #(
  parameter int unsigned ROW_BYTES   = drl_pkg::ROW_BYTES_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = drl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  drl_cmd_if.sink     cmd,
  drl_pix_if.source   pix,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]    graphics_base;
  drl_pkg::cmd_t  push_cmd;
  drl_pkg::cmd_t  head_cmd;
  logic           q_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == drl_pkg::REG_GRAPHICS_BASE) ? {16'd0, graphics_base} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      graphics_base <= '0;
    end else if (psel && penable && pwrite && paddr == drl_pkg::REG_GRAPHICS_BASE) begin
      graphics_base <= pwdata[15:0];
    end
  end

  drl_front u_front (
    .cmd    (cmd),
    .q_cmd  (push_cmd),
    .q_full (q_full),
    .q_push (q_push)
  );

  drl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_data (push_cmd),
    .wr_en   (q_push),
    .full    (q_full),
    .rd_data (head_cmd),
    .rd_en   (q_pop),
    .empty   (q_empty)
  );

  drl_back #(
    .ROW_BYTES (ROW_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .graphics_base (graphics_base),
    .q_cmd         (head_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pix           (pix)
  );

endmodule

// File: rtl/drl_checker.sv
// Port-level checker for the line rasterizer and its bind to the top level.
module drl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  pix_x,
  input logic [15:0] byte_address,
  input logic [5:0]  bit_mask
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_address) && $stable(pix_x))
    else $error("Stalled pixel item changed.");

  a_mask_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(bit_mask))
    else $error("Pixel mask is not one-hot.");

  a_mask_column: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bit_mask == drl_pkg::pix_mask(pix_x))
    else $error("Pixel mask does not match the column.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Pixel item valid right after reset.");

endmodule

bind dda_line_pixel_rasterizer_unit drl_checker u_drl_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (pix.valid),
  .out_ready    (pix.ready),
  .pix_x        (pix.pix_x),
  .byte_address (pix.byte_address),
  .bit_mask     (pix.bit_mask)
);
